/* design/assert_macros.svh */
// Assertion macros used by lfsu_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/lfsu_pkg.sv */
// ---------------------------------------------------------------------------
// lfsu_pkg
// Types, codes and constants shared by the lattice strategy update core.
// ---------------------------------------------------------------------------
`default_nettype none

package lfsu_pkg;

  localparam int SIDE_DEF      = 64;
  localparam int ENTRIES_DEF   = 256;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [1:0] ST_DEFECT = 2'd0;
  localparam logic [1:0] ST_COOP   = 2'd1;
  localparam logic [1:0] ST_QUASI  = 2'd2;
  localparam logic [1:0] ST_ALIAS  = 2'd3;

  localparam logic [1:0] OUT_WRITTEN  = 2'd0;
  localparam logic [1:0] OUT_SKIPPED  = 2'd1;
  localparam logic [1:0] OUT_REVERTED = 2'd2;
  localparam logic [1:0] OUT_ADOPTED  = 2'd3;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_M    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE = 3'd6;

  localparam logic [2:0] SEL_CENTRE = 3'd0;
  localparam logic [2:0] SEL_NORTH  = 3'd1;
  localparam logic [2:0] SEL_SOUTH  = 3'd2;
  localparam logic [2:0] SEL_EAST   = 3'd3;
  localparam logic [2:0] SEL_WEST   = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [11:0] site;
    logic [1:0]  strategy_value;
    logic        choice_bit;
    logic [15:0] accept_draw;
  } lfsu_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  new_strategy;
    logic [12:0] count_defect;
    logic [12:0] count_coop;
    logic [12:0] count_quasi;
  } lfsu_out_t;

  typedef struct packed {
    logic       clr_step;
    logic       load_req;
    logic       div_step;
    logic       div_mid;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       eval;
    logic       mul;
    logic       look1;
    logic       look2;
    logic       commit;
  } lfsu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_update;
    logic out_free;
  } lfsu_status_t;

endpackage

`default_nettype wire

/* design/lfsu_ctrl.sv */
// ---------------------------------------------------------------------------
// lfsu_ctrl
// Sequencer: clearing pass, site divide, grid reads, evaluation and commit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfsu_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lfsu_pkg::lfsu_status_t status,
  output lfsu_pkg::lfsu_cmd_t        cmd
);
  import lfsu_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_A, S_MID, S_DIV_B, S_READ, S_WAIT,
    S_EVAL, S_MUL, S_LOOK1, S_LOOK2, S_COMMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_req = in_valid;
        cnt_nxt      = '0;
        if (in_valid) state_nxt = S_DIV_A;
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_MID;
      end
      S_MID: begin
        cmd.div_mid = 1'b1;
        state_nxt   = S_DIV_B;
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_READ;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cnt_r[2:0];
        // A write request needs only the centre site.
        if (!status.is_update || cnt_r[2:0] == SEL_WEST) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_WAIT:  state_nxt = status.is_update ? S_EVAL : S_COMMIT;
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOOK1;
      end
      S_LOOK1: begin
        cmd.look1 = 1'b1;
        state_nxt = S_LOOK2;
      end
      S_LOOK2: begin
        cmd.look2 = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = status.out_free;
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `ASSERT_CLK(a_commit_free, cmd.commit |-> status.out_free, "commit while output busy")
  `ASSERT_CLK(a_load_div, cmd.load_req |=> (state_r == S_DIV_A), "request not taken to divide")
  `ASSERT_CLK_ALWAYS(a_one_action, $onehot0({cmd.clr_step, cmd.load_req, cmd.div_step,
    cmd.rd_en, cmd.commit}), "more than one datapath action at once")

endmodule

`default_nettype wire

/* design/lfsu_dp.sv */
// ---------------------------------------------------------------------------
// lfsu_dp
// Datapath: grid memory, counts, site divider, payoff sums and Fermi lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module lfsu_dp #(
  parameter int SIDE             = lfsu_pkg::SIDE_DEF,
  parameter int LOGISTIC_ENTRIES = lfsu_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lfsu_pkg::lfsu_cmd_t           cmd,
  output lfsu_pkg::lfsu_status_t             status,
  input  wire lfsu_pkg::lfsu_in_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lfsu_pkg::lfsu_out_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [lfsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfsu_pkg::*;

  localparam int CELLS  = SIDE * SIDE;
  localparam int RC_W   = $clog2(SIDE);
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int IDX_W  = $clog2(LOGISTIC_ENTRIES);
  localparam logic [63:0] FY = (64'd8 << 32) / LOGISTIC_ENTRIES;
  localparam logic [63:0] ONE32 = 64'd1 << 32;
  localparam int DIV_SH = 24;
  localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_SH) + 64'(SIDE) - 64'd1) / 64'(SIDE);
  localparam logic [23:0] DIV_M = DIV_M64[23:0];

  // exp(-n*h) in Q0.32 from a fourth-order series and repeated products.
  function automatic logic [63:0] fermi_e(input int n, input logic [63:0] y);
    logic [63:0] y2, y3, y4, r, e;
    y2 = (y * y) >> 32;
    y3 = (y2 * y) >> 32;
    y4 = (y3 * y) >> 32;
    r  = ONE32 + y2 / 2 + y4 / 24 - y - y3 / 6;
    e  = ONE32;
    for (int i = 0; i < n; i++) e = (e * r) >> 32;
    return e;
  endfunction

  logic [15:0] fermi_rom [LOGISTIC_ENTRIES];
  for (genvar gi = 0; gi < LOGISTIC_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] DEN = ONE32 + fermi_e(gi, FY);
    localparam logic [63:0] GV  = ((64'd1 << 48) + DEN / 2) / DEN;
    assign fermi_rom[gi] = GV[15:0];
  end

  // Configuration registers.
  logic signed [15:0] tempt_r, lambda_r, delta_r, gain_m_r, alpha_r, rho_r;
  logic        [15:0] inv_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempt_r     <= 16'sd384;
      lambda_r    <= '0;
      delta_r     <= '0;
      gain_m_r    <= '0;
      alpha_r     <= '0;
      rho_r       <= 16'sd256;
      inv_noise_r <= 16'd2560;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMPT:     tempt_r     <= cfg_wdata;
        CFG_LAMBDA:    lambda_r    <= cfg_wdata;
        CFG_DELTA:     delta_r     <= cfg_wdata;
        CFG_GAIN_M:    gain_m_r    <= cfg_wdata;
        CFG_ALPHA:     alpha_r     <= cfg_wdata;
        CFG_RHO:       rho_r       <= cfg_wdata;
        CFG_INV_NOISE: inv_noise_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [17:0] pay [9];
  always_comb begin
    pay[0] = '0;
    pay[1] = 18'(tempt_r);
    pay[2] = 18'(tempt_r) - 18'(lambda_r);
    pay[3] = -18'(delta_r);
    pay[4] = 18'sd256;
    pay[5] = 18'sd256 - 18'(alpha_r);
    pay[6] = 18'(gain_m_r) - 18'(delta_r);
    pay[7] = 18'sd256 + 18'(alpha_r);
    pay[8] = 18'(rho_r);
  end

  // Request and site divider. The quotient by SIDE comes from a reciprocal
  // multiplication, exact for every 12-bit dividend.
  lfsu_in_t         req_r;
  logic [11:0]      dvd_r, quot_r, quot_w;
  logic [RC_W-1:0]  rem_r, col_r, rem_w;
  logic [35:0]      qprod;
  logic [31:0]      back;

  assign qprod  = 36'(dvd_r) * 36'(DIV_M);
  assign quot_w = qprod[DIV_SH +: 12];
  assign back   = 32'(dvd_r) - 32'(quot_w) * 32'(SIDE);
  assign rem_w  = back[RC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
      dvd_r <= in_data.site;
    end else if (cmd.div_step) begin
      quot_r <= quot_w;
      rem_r  <= rem_w;
    end else if (cmd.div_mid) begin
      dvd_r <= quot_r;
      col_r <= rem_r;
    end
  end

  // Neighbour addresses; after the second divide step rem_r holds the row.
  logic [RC_W-1:0] row_up, row_dn, col_lf, col_rt, r_sel, c_sel;
  logic [CELL_W-1:0] rd_addr;

  always_comb begin
    row_up = (rem_r == '0) ? RC_W'(SIDE - 1) : rem_r - 1'b1;
    row_dn = (rem_r == RC_W'(SIDE - 1)) ? '0 : rem_r + 1'b1;
    col_lf = (col_r == '0) ? RC_W'(SIDE - 1) : col_r - 1'b1;
    col_rt = (col_r == RC_W'(SIDE - 1)) ? '0 : col_r + 1'b1;
    r_sel  = rem_r;
    c_sel  = col_r;
    unique case (cmd.rd_sel)
      SEL_NORTH: r_sel = row_up;
      SEL_SOUTH: r_sel = row_dn;
      SEL_EAST:  c_sel = col_rt;
      SEL_WEST:  c_sel = col_lf;
      default: ;
    endcase
    rd_addr = CELL_W'(32'(r_sel) * SIDE + 32'(c_sel));
  end

  // Grid memory.
  logic [1:0]        grid_mem [CELLS];
  logic [1:0]        rdata_r;
  logic              wr_en;
  logic [CELL_W-1:0] wr_addr, clr_addr_r, centre_addr_r;
  logic [1:0]        wr_data;
  logic              cap_vld_r;
  logic [2:0]        cap_sel_r;
  logic [1:0]        old_r;
  logic [1:0]        nb_r [4];

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r  <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      cap_vld_r <= cmd.rd_en;
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cap_sel_r <= cmd.rd_sel;
    if (cmd.rd_en && cmd.rd_sel == SEL_CENTRE) centre_addr_r <= rd_addr;
    if (cap_vld_r) begin
      unique case (cap_sel_r)
        SEL_CENTRE: old_r    <= rdata_r;
        SEL_NORTH:  nb_r[0]  <= rdata_r;
        SEL_SOUTH:  nb_r[1]  <= rdata_r;
        SEL_EAST:   nb_r[2]  <= rdata_r;
        SEL_WEST:   nb_r[3]  <= rdata_r;
        default: ;
      endcase
    end
  end

  // Alternative choice and payoff sums.
  logic [1:0]         alt1, alt2, alt_sel, alt_r;
  logic               held1, found_w, found_r;
  logic signed [19:0] earn_old_w, earn_alt_w, earn_old_r, earn_alt_r;

  always_comb begin
    unique case (old_r)
      ST_COOP:  alt1 = req_r.choice_bit ? ST_DEFECT : ST_QUASI;
      ST_QUASI: alt1 = req_r.choice_bit ? ST_COOP   : ST_DEFECT;
      default:  alt1 = req_r.choice_bit ? ST_QUASI  : ST_COOP;
    endcase
    // The three codes sum to three, so this is the remaining alternative.
    alt2    = 2'd3 - old_r - alt1;
    held1   = (nb_r[0] == alt1) || (nb_r[1] == alt1) ||
              (nb_r[2] == alt1) || (nb_r[3] == alt1);
    alt_sel = held1 ? alt1 : alt2;
    found_w = (nb_r[0] == alt_sel) || (nb_r[1] == alt_sel) ||
              (nb_r[2] == alt_sel) || (nb_r[3] == alt_sel);
    earn_old_w = '0;
    earn_alt_w = '0;
    for (int k = 0; k < 4; k++) begin
      earn_old_w = earn_old_w + 20'(pay[4'(old_r) * 4'd3 + 4'(nb_r[k])]);
      earn_alt_w = earn_alt_w + 20'(pay[4'(alt_sel) * 4'd3 + 4'(nb_r[k])]);
    end
  end

  // Scaled difference, table index and revert probability.
  logic signed [20:0] diff_w;
  logic signed [16:0] inv_s;
  logic signed [37:0] t_w, t_r;
  logic        [37:0] mag;
  logic        [29:0] prod;
  logic               neg_r, sat_r;
  logic [IDX_W-1:0]   idx_r;
  logic        [16:0] p_r;
  logic        [16:0] g17;

  assign diff_w = 21'(earn_alt_r) - 21'(earn_old_r);
  assign inv_s  = {1'b0, inv_noise_r};
  assign t_w    = 38'(diff_w) * 38'(inv_s);
  assign mag    = t_r[37] ? 38'(-t_r) : 38'(t_r);
  assign prod   = 30'(mag[18:0]) * 30'(LOGISTIC_ENTRIES);
  assign g17    = {1'b0, fermi_rom[idx_r]};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      alt_r      <= alt_sel;
      found_r    <= found_w;
      earn_old_r <= earn_old_w;
      earn_alt_r <= earn_alt_w;
    end
    if (cmd.mul) t_r <= t_w;
    if (cmd.look1) begin
      neg_r <= t_r[37];
      // A magnitude at or above 2^19 indexes past the end of the table.
      sat_r <= |mag[37:19];
      idx_r <= prod[19 +: IDX_W];
    end
    if (cmd.look2) begin
      if (neg_r) p_r <= sat_r ? 17'd65536 : 17'd65536 - g17;
      else       p_r <= sat_r ? 17'd0 : g17;
    end
  end

  // Commit: outcome, counts and write-back.
  logic [1:0]       wv, outcome_w, new_w;
  logic             chg;
  logic [CNT_W-1:0] cnt_d_r, cnt_c_r, cnt_q_r, cnt_d_nxt, cnt_c_nxt, cnt_q_nxt;

  always_comb begin
    wv = (req_r.strategy_value == ST_ALIAS) ? ST_DEFECT : req_r.strategy_value;
    priority if (req_r.req_type == REQ_WRITE) begin
      outcome_w = OUT_WRITTEN;
      new_w     = wv;
      chg       = 1'b1;
    end else if (!found_r) begin
      outcome_w = OUT_SKIPPED;
      new_w     = old_r;
      chg       = 1'b0;
    end else if ({1'b0, req_r.accept_draw} < p_r) begin
      outcome_w = OUT_REVERTED;
      new_w     = old_r;
      chg       = 1'b0;
    end else begin
      outcome_w = OUT_ADOPTED;
      new_w     = alt_r;
      chg       = 1'b1;
    end
    cnt_d_nxt = cnt_d_r + CNT_W'(new_w == ST_DEFECT) - CNT_W'(old_r == ST_DEFECT);
    cnt_c_nxt = cnt_c_r + CNT_W'(new_w == ST_COOP)   - CNT_W'(old_r == ST_COOP);
    cnt_q_nxt = cnt_q_r + CNT_W'(new_w == ST_QUASI)  - CNT_W'(old_r == ST_QUASI);
    wr_en   = cmd.clr_step || (cmd.commit && chg);
    wr_addr = cmd.clr_step ? clr_addr_r : centre_addr_r;
    wr_data = cmd.clr_step ? ST_DEFECT : new_w;
  end

  logic [31:0] cd32, cc32, cq32;
  assign cd32 = 32'(cnt_d_nxt);
  assign cc32 = 32'(cnt_c_nxt);
  assign cq32 = 32'(cnt_q_nxt);

  logic      out_valid_r;
  lfsu_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_d_r     <= CNT_W'(CELLS);
      cnt_c_r     <= '0;
      cnt_q_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (chg) begin
          cnt_d_r <= cnt_d_nxt;
          cnt_c_r <= cnt_c_nxt;
          cnt_q_r <= cnt_q_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.outcome      <= outcome_w;
      out_data_r.new_strategy <= new_w;
      out_data_r.count_defect <= chg ? cd32[12:0] : 13'(32'(cnt_d_r));
      out_data_r.count_coop   <= chg ? cc32[12:0] : 13'(32'(cnt_c_r));
      out_data_r.count_quasi  <= chg ? cq32[12:0] : 13'(32'(cnt_q_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.clr_last  = (clr_addr_r == CELL_W'(CELLS - 1));
  assign status.is_update = (req_r.req_type == REQ_UPDATE);
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

/* design/lattice_fermi_strategy_update_core.sv */
// ---------------------------------------------------------------------------
// lattice_fermi_strategy_update_core
// Toroidal three-strategy grid with site writes and Fermi-rule updates.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  lfsu_in_t
// out      output     out_valid/out_stall  lfsu_out_t
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// Each request runs two divide steps by reciprocal multiplication around one
// transfer step, then one grid read per site through the single memory read
// port; an update then takes four evaluation steps before commit. The next
// request is accepted in the cycle after the commit.
// After reset a clearing pass zeroes the grid; no request is accepted during
// it. A stalled result holds in the output register; the next request is
// accepted meanwhile and waits at commit until it drains.
`default_nettype none

module lattice_fermi_strategy_update_core #(
  parameter int SIDE             = lfsu_pkg::SIDE_DEF,
  parameter int LOGISTIC_ENTRIES = lfsu_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lfsu_pkg::lfsu_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lfsu_pkg::lfsu_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [lfsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfsu_pkg::*;

  lfsu_cmd_t    cmd;
  lfsu_status_t status;

  lfsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfsu_dp #(
    .SIDE             (SIDE),
    .LOGISTIC_ENTRIES (LOGISTIC_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// Lattice strategy update core testbench
// Drives site writes and update requests with random gaps and stalls, predicts
// every result from its own copy of the grid, counts, payoffs and logistic
// table, and checks each result field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

class lattice_scoreboard;
  localparam int SIDE = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int ENTRIES = 256;

  logic [1:0] grid [CELLS];
  int unsigned totals [3];
  longint signed tempt, lambda, delta, gain_m, alpha, rho;
  longint unsigned inv_noise;
  longint unsigned logistic [ENTRIES];
  lfsu_pkg::lfsu_out_t pending [$];
  int errors;

  function new();
    longint unsigned one, y, y2, y3, y4, r, e, den;
    one = 64'd1 << 32;
    y = (64'd8 << 32) / ENTRIES;
    y2 = (y * y) >> 32;
    y3 = (y2 * y) >> 32;
    y4 = (y3 * y) >> 32;
    r = one + y2 / 2 + y4 / 24 - y - y3 / 6;
    e = one;
    for (int i = 0; i < ENTRIES; i++) begin
      den = one + e;
      logistic[i] = ((64'd1 << 48) + den / 2) / den;
      e = (e * r) >> 32;
    end
    for (int i = 0; i < CELLS; i++) grid[i] = lfsu_pkg::ST_DEFECT;
    totals[0] = CELLS;
    totals[1] = 0;
    totals[2] = 0;
    tempt = 384; lambda = 0; delta = 0; gain_m = 0; alpha = 0; rho = 256;
    inv_noise = 2560;
    errors = 0;
  endfunction

  function void set_register(logic [2:0] idx, logic [15:0] v);
    case (idx)
      lfsu_pkg::CFG_TEMPT:     tempt = $signed(v);
      lfsu_pkg::CFG_LAMBDA:    lambda = $signed(v);
      lfsu_pkg::CFG_DELTA:     delta = $signed(v);
      lfsu_pkg::CFG_GAIN_M:    gain_m = $signed(v);
      lfsu_pkg::CFG_ALPHA:     alpha = $signed(v);
      lfsu_pkg::CFG_RHO:       rho = $signed(v);
      lfsu_pkg::CFG_INV_NOISE: inv_noise = v;
      default: ;
    endcase
  endfunction

  function longint signed payoff(int me, int other);
    case (me * 3 + other)
      0: return 0;
      1: return tempt;
      2: return tempt - lambda;
      3: return -delta;
      4: return 256;
      5: return 256 - alpha;
      6: return gain_m - delta;
      7: return 256 + alpha;
      default: return rho;
    endcase
  endfunction

  function longint signed earnings(int me, int nb[4]);
    longint signed sum = 0;
    for (int k = 0; k < 4; k++) sum += payoff(me, grid[nb[k]]);
    return sum;
  endfunction

  function bit held_by_neighbour(int s, int nb[4]);
    for (int k = 0; k < 4; k++) if (grid[nb[k]] == s) return 1;
    return 0;
  endfunction

  function longint unsigned revert_chance(longint signed t);
    longint unsigned mag, idx;
    mag = (t < 0) ? -t : t;
    idx = (mag * ENTRIES) >> 19;
    if (idx >= ENTRIES) return (t < 0) ? 65536 : 0;
    return (t < 0) ? 65536 - logistic[idx] : logistic[idx];
  endfunction

  function void note_request(lfsu_pkg::lfsu_in_t rq);
    lfsu_pkg::lfsu_out_t res;
    int s, prior, alt, row, col, v;
    int nb[4];
    longint signed diff;
    s = rq.site % CELLS;
    prior = grid[s];
    if (rq.req_type == lfsu_pkg::REQ_WRITE) begin
      v = (rq.strategy_value == lfsu_pkg::ST_ALIAS) ? 0 : rq.strategy_value;
      totals[prior]--;
      totals[v]++;
      grid[s] = 2'(v);
      res.outcome = lfsu_pkg::OUT_WRITTEN;
      res.new_strategy = 2'(v);
    end else begin
      row = s / SIDE;
      col = s % SIDE;
      nb[0] = ((row + SIDE - 1) % SIDE) * SIDE + col;
      nb[1] = ((row + 1) % SIDE) * SIDE + col;
      nb[2] = row * SIDE + (col + 1) % SIDE;
      nb[3] = row * SIDE + (col + SIDE - 1) % SIDE;
      alt = (prior + 1 + rq.choice_bit) % 3;
      if (!held_by_neighbour(alt, nb)) alt = (2 * prior + 3 - alt) % 3;
      if (!held_by_neighbour(alt, nb)) begin
        res.outcome = lfsu_pkg::OUT_SKIPPED;
        res.new_strategy = 2'(prior);
      end else begin
        diff = earnings(alt, nb) - earnings(prior, nb);
        if (rq.accept_draw < revert_chance(diff * longint'(inv_noise))) begin
          res.outcome = lfsu_pkg::OUT_REVERTED;
          res.new_strategy = 2'(prior);
        end else begin
          totals[prior]--;
          totals[alt]++;
          grid[s] = 2'(alt);
          res.outcome = lfsu_pkg::OUT_ADOPTED;
          res.new_strategy = 2'(alt);
        end
      end
    end
    res.count_defect = 13'(totals[0]);
    res.count_coop = 13'(totals[1]);
    res.count_quasi = 13'(totals[2]);
    pending.push_back(res);
  endfunction

  function void check_result(lfsu_pkg::lfsu_out_t got);
    lfsu_pkg::lfsu_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.outcome !== want.outcome)
      $display("%0t: outcome expected %0d actual %0d", $realtime, want.outcome, got.outcome);
    if (got.new_strategy !== want.new_strategy)
      $display("%0t: new_strategy expected %0d actual %0d", $realtime,
               want.new_strategy, got.new_strategy);
    if (got.count_defect !== want.count_defect)
      $display("%0t: count_defect expected %0d actual %0d", $realtime,
               want.count_defect, got.count_defect);
    if (got.count_coop !== want.count_coop)
      $display("%0t: count_coop expected %0d actual %0d", $realtime,
               want.count_coop, got.count_coop);
    if (got.count_quasi !== want.count_quasi)
      $display("%0t: count_quasi expected %0d actual %0d", $realtime,
               want.count_quasi, got.count_quasi);
    if (got !== want) errors++;
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfsu_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lfsu_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lfsu_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lattice_scoreboard board = new();
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit timed_out = 1'b0;

  lattice_fermi_strategy_update_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("lattice_fermi_strategy_update_core test failed");
      $finish;
    end
  end

  // Result side: checks accepted results and stalls at random or while hold_off is set.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 6) > $urandom_range(0, 6) + 2);
    end
  end

  // Valid stays high into the next request when there is no gap.
  task automatic send(lfsu_in_t rq);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    board.note_request(rq);
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_register(idx, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic lfsu_in_t make(logic kind, int s, int v, bit cb, int draw);
    lfsu_in_t rq;
    rq.req_type = kind;
    rq.site = 12'(s);
    rq.strategy_value = 2'(v);
    rq.choice_bit = cb;
    rq.accept_draw = 16'(draw);
    return rq;
  endfunction

  // Random requests, clustered in a small window unless window is zero, so updates see mixed neighbours.
  function automatic lfsu_in_t random_request(int window);
    int s;
    s = (window == 0) ? $urandom_range(0, 4095) : 64 * $urandom_range(0, window - 1)
        + $urandom_range(0, window - 1);
    return make(($urandom_range(0, 9) < 6) ? REQ_UPDATE : REQ_WRITE, s,
                $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, the value three alias, isolated skip and both choices.
    send(make(REQ_UPDATE, 0, 0, 0, 0));
    send(make(REQ_WRITE, 0, 1, 1, 65535));
    send(make(REQ_WRITE, 4095, 2, 0, 0));
    send(make(REQ_WRITE, 63, 3, 0, 0));
    send(make(REQ_WRITE, 64, 2, 0, 0));
    send(make(REQ_UPDATE, 4032, 3, 0, 0));
    send(make(REQ_UPDATE, 4032, 0, 1, 65535));
    send(make(REQ_UPDATE, 1, 0, 0, 0));
    send(make(REQ_UPDATE, 1, 0, 1, 32768));
    send(make(REQ_UPDATE, 0, 0, 0, 65535));
    send(make(REQ_UPDATE, 0, 0, 1, 0));
    send(make(REQ_WRITE, 2048, 1, 0, 0));
    send(make(REQ_UPDATE, 2048, 0, 1, 65535));
    send(make(REQ_UPDATE, 2049, 0, 0, 1));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 7; r++) begin
        case (phase)
          0: write_register(3'(r), 16'h8000);
          1: write_register(3'(r), 16'h7FFF);
          2: write_register(3'(r), (r == 6) ? 16'd0 : 16'hFFFF);
          3: write_register(3'(r), (r == 6) ? 16'hFFFF : 16'd1);
          default: write_register(3'(r),
                                  16'($urandom_range(0, 65535) >> $urandom_range(0, 12)));
        endcase
      end
      cfg_we <= 1'b0;
      if (phase == 2) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int i = 0; i < 200; i++) send(random_request((phase == 7 || i % 9 == 0) ? 0 : 6));
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("lattice_fermi_strategy_update_core test passed");
    else
      $display("lattice_fermi_strategy_update_core test failed");
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/lfsu_pkg.sv
design/lfsu_ctrl.sv
design/lfsu_dp.sv
design/lattice_fermi_strategy_update_core.sv
verif/testbench.sv
